FILE: rtl/qpd_pkg.sv
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types, opcodes and the color hash for the QOI pixel decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

  localparam logic [7:0] OPC_RGB  = 8'hFE;
  localparam logic [7:0] OPC_RGBA = 8'hFF;

  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  localparam int unsigned IndexDepth = 64;
  localparam int unsigned IndexAw    = $clog2(IndexDepth);
  localparam logic [5:0]  RunMax     = 6'd62;
  localparam logic [31:0] PxReset    = 32'h0000_00FF;

  // Which pixel source a commit takes
  typedef enum logic [2:0] {
    CM_NONE,
    CM_RGB,
    CM_RGBA,
    CM_LUMA,
    CM_DIFF,
    CM_INDEX,
    CM_RUN
  } commit_e;

  typedef enum logic [1:0] {
    GA_HOLD,
    GA_CLEAR,
    GA_LOAD,
    GA_SHIFT
  } gather_e;

  typedef struct packed {
    logic    start;
    logic    read_idx;
    gather_e gather;
    commit_e commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // (3r + 5g + 7b + 11a) mod 64; only the low six bits of each channel matter
  function automatic logic [IndexAw-1:0] px_hash(logic [31:0] px);
    logic [IndexAw-1:0] r;
    logic [IndexAw-1:0] g;
    logic [IndexAw-1:0] b;
    logic [IndexAw-1:0] a;
    r = px[24 +: IndexAw];
    g = px[16 +: IndexAw];
    b = px[8 +: IndexAw];
    a = px[0 +: IndexAw];
    return r * IndexAw'(3) + g * IndexAw'(5) + b * IndexAw'(7) + a * IndexAw'(11);
  endfunction

endpackage

FILE: rtl/qpd_ctrl.sv
// ----------------------------------------------------------------------------
// qpd_ctrl
// Opcode decoder and sequencer: tracks the multi-byte op in flight and
// issues commit, gather and index-read commands to the datapath.
// ----------------------------------------------------------------------------
module qpd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            image_start_i,
  input  qpd_pkg::status_t status_i,
  output qpd_pkg::cmd_t   cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef enum logic [1:0] {
    PO_NONE,
    PO_RGB,
    PO_RGBA,
    PO_LUMA
  } pend_e;

  state_e     state_q, state_d;
  pend_e      pend_q, pend_d;
  logic [2:0] owed_q, owed_d;
  logic       accept;

  assign in_stall_o = !((state_q == S_IDLE) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d         = state_q;
    pend_d          = pend_q;
    owed_d          = owed_q;
    cmd_o.start     = accept && image_start_i;
    cmd_o.read_idx  = 1'b0;
    cmd_o.gather    = qpd_pkg::GA_HOLD;
    cmd_o.commit    = qpd_pkg::CM_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (pend_q != PO_NONE && !image_start_i) begin
            // operand byte of the op in flight
            owed_d = owed_q - 3'd1;
            if (owed_q == 3'd1) begin
              pend_d = PO_NONE;
              unique case (pend_q)
                PO_RGB:  cmd_o.commit = qpd_pkg::CM_RGB;
                PO_RGBA: cmd_o.commit = qpd_pkg::CM_RGBA;
                PO_LUMA: cmd_o.commit = qpd_pkg::CM_LUMA;
                default: cmd_o.commit = qpd_pkg::CM_NONE;
              endcase
            end else begin
              cmd_o.gather = qpd_pkg::GA_SHIFT;
            end
          end else if (data_byte_i == qpd_pkg::OPC_RGB) begin
            pend_d       = PO_RGB;
            owed_d       = 3'd3;
            cmd_o.gather = qpd_pkg::GA_CLEAR;
          end else if (data_byte_i == qpd_pkg::OPC_RGBA) begin
            pend_d       = PO_RGBA;
            owed_d       = 3'd4;
            cmd_o.gather = qpd_pkg::GA_CLEAR;
          end else begin
            pend_d = PO_NONE;
            owed_d = 3'd0;
            unique case (data_byte_i[7:6])
              qpd_pkg::TAG_INDEX: begin
                cmd_o.read_idx = 1'b1;
                state_d        = S_READ;
              end
              qpd_pkg::TAG_DIFF: cmd_o.commit = qpd_pkg::CM_DIFF;
              qpd_pkg::TAG_LUMA: begin
                pend_d       = PO_LUMA;
                owed_d       = 3'd1;
                cmd_o.gather = qpd_pkg::GA_LOAD;
              end
              default: cmd_o.commit = qpd_pkg::CM_RUN;
            endcase
          end
        end
      end
      S_READ: begin
        // index data is registered now
        cmd_o.commit = qpd_pkg::CM_INDEX;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= PO_NONE;
      owed_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      owed_q  <= owed_d;
    end
  end

  a_owed_matches_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == PO_NONE) == (owed_q == 3'd0))
    else $error("operand count out of step with pending op");

  a_read_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.read_idx |=> (state_q == S_READ) ##1 (state_q == S_IDLE))
    else $error("index read did not complete in one cycle");

  a_no_accept_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !accept)
    else $error("byte accepted during index read");

endmodule

FILE: rtl/qpd_datapath.sv
// ----------------------------------------------------------------------------
// qpd_datapath
// Previous pixel, 64-entry color index, operand gather register, pixel
// reconstruction and the output register with its run counter.
// ----------------------------------------------------------------------------
module qpd_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       data_byte_i,
  input  qpd_pkg::cmd_t    cmd_i,
  output qpd_pkg::status_t status_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o,
  output logic             last_of_burst_o
);

  localparam int unsigned Aw = qpd_pkg::IndexAw;

  logic [31:0]                     prev_q;
  logic [31:0]                     prev_d;
  logic [31:0]                     prev_eff;
  logic [23:0]                     gather_q;
  logic [31:0]                     gb_now;
  logic [31:0]                     mem_q [qpd_pkg::IndexDepth];
  logic [qpd_pkg::IndexDepth-1:0]  valid_q;
  logic [qpd_pkg::IndexDepth-1:0]  valid_d;
  logic [31:0]                     rd_data_q;
  logic                            rd_valid_q;
  logic [31:0]                     px_q;
  logic [5:0]                      count_q;
  logic [31:0]                     px_new;
  logic [5:0]                      count_new;
  logic                            commit;
  logic [Aw-1:0]                   wr_addr;
  logic [7:0]                      dg8, drg8, dbg8;
  logic [7:0]                      dr2, dg2, db2;
  logic                            out_take;

  // A start byte sees the reset pixel
  assign prev_eff = cmd_i.start ? qpd_pkg::PxReset : prev_q;
  assign gb_now   = {gather_q, data_byte_i};

  assign dg8  = {2'b00, gb_now[13:8]} - 8'd32;
  assign drg8 = {4'b0000, gb_now[7:4]} - 8'd8;
  assign dbg8 = {4'b0000, gb_now[3:0]} - 8'd8;
  assign dr2  = {6'b0, data_byte_i[5:4]} - 8'd2;
  assign dg2  = {6'b0, data_byte_i[3:2]} - 8'd2;
  assign db2  = {6'b0, data_byte_i[1:0]} - 8'd2;

  always_comb begin
    count_new = 6'd1;
    unique case (cmd_i.commit)
      qpd_pkg::CM_RGB:  px_new = {gb_now[23:0], prev_eff[7:0]};
      qpd_pkg::CM_RGBA: px_new = gb_now;
      qpd_pkg::CM_LUMA: px_new = {prev_eff[31:24] + dg8 + drg8,
                                  prev_eff[23:16] + dg8,
                                  prev_eff[15:8] + dg8 + dbg8,
                                  prev_eff[7:0]};
      qpd_pkg::CM_DIFF: px_new = {prev_eff[31:24] + dr2,
                                  prev_eff[23:16] + dg2,
                                  prev_eff[15:8] + db2,
                                  prev_eff[7:0]};
      qpd_pkg::CM_INDEX: px_new = rd_valid_q ? rd_data_q : 32'd0;
      qpd_pkg::CM_RUN: begin
        px_new    = prev_eff;
        count_new = data_byte_i[5:0] + 6'd1;
      end
      default: px_new = prev_eff;
    endcase
  end

  assign commit  = (cmd_i.commit != qpd_pkg::CM_NONE);
  assign wr_addr = qpd_pkg::px_hash(px_new);

  // A start clears the index before this byte's own pixel lands in it
  always_comb begin
    valid_d = cmd_i.start ? '0 : valid_q;
    if (commit) begin
      valid_d[wr_addr] = 1'b1;
    end
  end

  assign prev_d = commit ? px_new : prev_eff;

  assign out_valid_o       = (count_q != 6'd0);
  assign out_take          = out_valid_o && !out_stall_i;
  assign last_of_burst_o   = (count_q == 6'd1);
  assign status_o.out_free = (count_q == 6'd0) || (last_of_burst_o && !out_stall_i);
  assign red_o             = px_q[31:24];
  assign green_o           = px_q[23:16];
  assign blue_o            = px_q[15:8];
  assign alpha_o           = px_q[7:0];

  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem_q[wr_addr] <= px_new;
    end
    if (cmd_i.read_idx) begin
      rd_data_q <= mem_q[data_byte_i[Aw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      prev_q     <= qpd_pkg::PxReset;
      count_q    <= 6'd0;
    end else begin
      if (cmd_i.read_idx) begin
        rd_valid_q <= valid_q[data_byte_i[Aw-1:0]] && !cmd_i.start;
      end
      valid_q <= valid_d;
      prev_q  <= prev_d;
      if (commit) begin
        count_q <= count_new;
      end else if (out_take) begin
        count_q <= count_q - 6'd1;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.gather == qpd_pkg::GA_CLEAR) begin
      gather_q <= 24'd0;
    end else if (cmd_i.gather == qpd_pkg::GA_LOAD) begin
      gather_q <= {16'd0, data_byte_i};
    end else if (cmd_i.gather == qpd_pkg::GA_SHIFT) begin
      gather_q <= gb_now[23:0];
    end
    if (commit) begin
      px_q <= px_new;
    end
  end

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= qpd_pkg::RunMax)
    else $error("pixel count above longest run");

  a_commit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> status_o.out_free)
    else $error("commit overwrote a pending pixel");

  a_prev_tracks_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (px_q == prev_q))
    else $error("output pixel differs from previous pixel");

endmodule

FILE: rtl/qoi_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// qoi_pixel_decoder_unit
// QOI chunk-stream decoder: one byte in, zero or more RGBA pixels out.
// ----------------------------------------------------------------------------
// Output: a pixel is registered and shown the cycle after its last byte; an
//   INDEX pixel first passes through the registered index read.
// Throughput: one byte per cycle while the output register is free; a run
//   holds the input until its last pixel is taken, set by the single output
//   register, and an INDEX byte holds it during the registered index read.
// Reset: previous pixel goes to opaque black and all 64 index valid bits clear
//   at once; no clearing pass, the block takes bytes right after reset.
module qoi_pixel_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       image_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic       last_of_burst_o
);

  qpd_pkg::cmd_t    cmd;
  qpd_pkg::status_t status;

  qpd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .image_start_i (image_start_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  qpd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (data_byte_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .last_of_burst_o (last_of_burst_o)
  );

endmodule

FILE: dv/tb_qoi_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_qoi_pixel_decoder_unit
// Self-checking bench for the QOI byte-stream pixel decoder. A short table of
// hand-picked bytes runs first, then random chunk sequences. Every accepted
// byte is decoded by a behavioral pixel decoder in the bench. Each pixel the
// block emits is compared channel by channel against the oldest pending pixel.
// ----------------------------------------------------------------------------
module tb_qoi_pixel_decoder_unit;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef struct packed {
    rgba_t px;
    logic  last;
  } pixel_exp_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_RGB,
    PEND_RGBA,
    PEND_LUMA
  } pend_e;

  // Directed row: when known is set, px is the single pixel the byte yields
  typedef struct packed {
    logic [7:0]  code;
    logic        start;
    logic        known;
    logic [31:0] px;
  } dir_row_t;

  localparam int unsigned NumDirRows = 26;
  localparam int unsigned PhaseBytes = 131;

  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000},  // index read right after start
    '{8'hC0, 1'b0, 1'b1, 32'h0000_0000},  // single-pixel run
    '{8'hFE, 1'b1, 1'b0, 32'h0},          // RGB keeps reset alpha
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h80, 1'b0, 1'b1, 32'hFF00_80FF},
    '{8'hFF, 1'b0, 1'b0, 32'h0},          // RGBA with opcode-looking operands
    '{8'hFE, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h01, 1'b0, 1'b1, 32'hFEFF_0001},
    '{8'h6A, 1'b0, 1'b1, 32'hFEFF_0001},  // zero diff
    '{8'h40, 1'b0, 1'b1, 32'hFCFD_FE01},  // diff -2, blue wraps below zero
    '{8'h7F, 1'b0, 1'b1, 32'hFDFE_FF01},  // diff +1
    '{8'h80, 1'b0, 1'b0, 32'h0},          // luma, all deltas at minimum
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'hBF, 1'b0, 1'b0, 32'h0},          // luma, all deltas at maximum
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'h3F, 1'b0, 1'b0, 32'h0},
    '{8'hFD, 1'b0, 1'b0, 32'h0},          // longest run
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'h12, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000},  // start drops the half-done RGBA
    '{8'h80, 1'b1, 1'b0, 32'h0},
    '{8'hAA, 1'b1, 1'b0, 32'h0},          // start drops the pending luma
    '{8'h88, 1'b0, 1'b0, 32'h0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       image_start_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;
  logic [7:0] alpha_o;
  logic       last_of_burst_o;

  qoi_pixel_decoder_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .image_start_i  (image_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .last_of_burst_o(last_of_burst_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder state mirrored in the bench
  rgba_t       prev_px;
  rgba_t       color_table [64];
  pend_e       pend_op;
  int unsigned bytes_owed;
  logic [31:0] gathered;

  pixel_exp_t  pixel_q [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned starts_sent;
  int unsigned pixels_seen;
  int unsigned longest_burst;
  logic        force_start;

  function automatic logic [5:0] color_slot(rgba_t px);
    int unsigned sum;
    sum = 3 * px.r + 5 * px.g + 7 * px.b + 11 * px.a;
    return sum[5:0];
  endfunction

  function automatic void commit_pixel(rgba_t px, ref pixel_exp_t burst [$]);
    prev_px = px;
    color_table[color_slot(px)] = px;
    burst.push_back('{px: px, last: 1'b1});
  endfunction

  // Pixels produced by one accepted byte, in emission order
  function automatic void decode_byte(input logic [7:0] code, input logic st,
                                      ref pixel_exp_t burst [$]);
    rgba_t       px;
    int unsigned count;
    if (st) begin
      prev_px = 32'h0000_00FF;
      foreach (color_table[i]) color_table[i] = '0;
      pend_op = PEND_NONE;
      bytes_owed = 0;
    end
    if (pend_op != PEND_NONE) begin
      gathered = {gathered[23:0], code};
      if (bytes_owed > 0) bytes_owed--;
      if (bytes_owed != 0) return;
      case (pend_op)
        PEND_RGB:  px = {gathered[23:0], prev_px.a};
        PEND_RGBA: px = gathered;
        default: begin
          px.r = prev_px.r + gathered[13:8] - 8'd32 + gathered[7:4] - 8'd8;
          px.g = prev_px.g + gathered[13:8] - 8'd32;
          px.b = prev_px.b + gathered[13:8] - 8'd32 + gathered[3:0] - 8'd8;
          px.a = prev_px.a;
        end
      endcase
      pend_op = PEND_NONE;
      commit_pixel(px, burst);
      return;
    end
    if (code == qpd_pkg::OPC_RGB || code == qpd_pkg::OPC_RGBA) begin
      pend_op = (code == qpd_pkg::OPC_RGB) ? PEND_RGB : PEND_RGBA;
      bytes_owed = (code == qpd_pkg::OPC_RGB) ? 3 : 4;
      gathered = '0;
      return;
    end
    case (code[7:6])
      qpd_pkg::TAG_INDEX: commit_pixel(color_table[code[5:0]], burst);
      qpd_pkg::TAG_DIFF: begin
        px.r = prev_px.r + code[5:4] - 8'd2;
        px.g = prev_px.g + code[3:2] - 8'd2;
        px.b = prev_px.b + code[1:0] - 8'd2;
        px.a = prev_px.a;
        commit_pixel(px, burst);
      end
      qpd_pkg::TAG_LUMA: begin
        pend_op = PEND_LUMA;
        bytes_owed = 1;
        gathered = {24'h0, code};
      end
      default: begin
        // Run repeats the previous pixel and indexes it once
        count = code[5:0] + 1;
        color_table[color_slot(prev_px)] = prev_px;
        for (int unsigned k = 0; k < count; k++)
          burst.push_back('{px: prev_px, last: (k == count - 1)});
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] code, input logic st, input logic known,
                           input logic [31:0] known_px);
    pixel_exp_t burst [$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= code;
    image_start_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (st) starts_sent++;
    decode_byte(code, st, burst);
    if (burst.size() > longest_burst) longest_burst = burst.size();
    if (known) pixel_q.push_back('{px: known_px, last: 1'b1});
    else foreach (burst[i]) pixel_q.push_back(burst[i]);
  endtask

  task automatic push_byte(input logic [7:0] code, input logic st);
    send_byte(code, st, 1'b0, 32'h0);
  endtask

  // One chunk with random content; now and then a raw byte or a cut-short chunk
  task automatic send_random_op();
    int unsigned sel;
    int unsigned operands;
    logic        st;
    st = force_start || ($urandom_range(99) < 4);
    force_start = 1'b0;
    operands = 0;
    sel = $urandom_range(99);
    if (sel < 8) begin
      push_byte(8'($urandom), st | ($urandom_range(3) == 0));
    end else if (sel < 22) begin
      push_byte(qpd_pkg::OPC_RGB, st);
      operands = 3;
    end else if (sel < 36) begin
      push_byte(qpd_pkg::OPC_RGBA, st);
      operands = 4;
    end else if (sel < 54) begin
      push_byte({qpd_pkg::TAG_INDEX, 6'($urandom)}, st);
    end else if (sel < 70) begin
      push_byte({qpd_pkg::TAG_DIFF, 6'($urandom)}, st);
    end else if (sel < 86) begin
      push_byte({qpd_pkg::TAG_LUMA, 6'($urandom)}, st);
      operands = 1;
    end else begin
      // mostly short runs, a few long ones
      push_byte({qpd_pkg::TAG_RUN, 6'(($urandom_range(7) == 0) ? $urandom_range(61)
                                                                : $urandom_range(5))},
                st);
    end
    if (operands != 0 && $urandom_range(11) == 0) begin
      operands = $urandom_range(operands - 1);
      force_start = 1'b1;
    end
    for (int unsigned k = 0; k < operands; k++) push_byte(8'($urandom), 1'b0);
  endtask

  // Hold the input until every pending pixel is out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    pixel_exp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          if (errors < 10)
            $display("ERROR: unexpected pixel r=%02h g=%02h b=%02h a=%02h last=%0b",
                     red_o, green_o, blue_o, alpha_o, last_of_burst_o);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (red_o !== want.px.r || green_o !== want.px.g || blue_o !== want.px.b ||
              alpha_o !== want.px.a || last_of_burst_o !== want.last) begin
            if (errors < 10)
              $display("ERROR: pixel %0d exp %08h/%0b got %02h%02h%02h%02h/%0b",
                       pixels_seen, want.px, want.last,
                       red_o, green_o, blue_o, alpha_o, last_of_burst_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    int unsigned phase_start;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    image_start_i = 1'b0;
    out_stall_i   = 1'b0;
    prev_px       = 32'h0000_00FF;
    foreach (color_table[i]) color_table[i] = '0;
    pend_op       = PEND_NONE;
    bytes_owed    = 0;
    gathered      = '0;
    errors        = 0;
    bytes_sent    = 0;
    starts_sent   = 0;
    pixels_seen   = 0;
    longest_burst = 0;
    force_start   = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 77;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i])
      send_byte(DirRows[i].code, DirRows[i].start, DirRows[i].known, DirRows[i].px);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 32 : (p == 1) ? 77 : 0;
      recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 32 : 0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_random_op();
      wait_drained();
    end

    // let any stray pixel show up
    repeat (20) @(posedge clk_i);
    if (pixel_q.size() != 0) begin
      $display("ERROR: %0d pixels never arrived", pixel_q.size());
      errors++;
    end
    $display("Fed %0d bytes (%0d image starts) across three idle mixes", bytes_sent,
             starts_sent);
    $display("Checked %0d pixels, longest burst %0d, %0d mismatches", pixels_seen,
             longest_burst, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("ERROR: timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/qpd_pkg.sv
rtl/qpd_ctrl.sv
rtl/qpd_datapath.sv
rtl/qoi_pixel_decoder_unit.sv
dv/tb_qoi_pixel_decoder_unit.sv
